// ===== hdl/dtlsrw_pkg.sv =====
// Shared constants, status codes and result type for the DTLS replay window.
package dtlsrw_pkg;

    localparam int WINDOW_BITS = 64;
    localparam int EPOCH_W     = 16;
    localparam int SEQ_W       = 48;
    localparam int RECORD_W    = EPOCH_W + SEQ_W;
    localparam int OFF_W       = $clog2(WINDOW_BITS);
    localparam int CNT_W       = $clog2(WINDOW_BITS + 1);
    localparam int STATUS_W    = 2;
    localparam int OUT_BITS    = STATUS_W + SEQ_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WRONG_EPOCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [WINDOW_BITS-1:0] bitmap;
        logic [SEQ_W-1:0]       start;
    } chk_result_t;

endpackage

// ===== hdl/dtlsrw_check.sv =====
// Window check and update: epoch, range, duplicate test, trailing-ones slide.
module dtlsrw_check
    import dtlsrw_pkg::*;
(
    input  logic [RECORD_W-1:0]    record_number,
    input  logic [EPOCH_W-1:0]     current_epoch,
    input  logic [WINDOW_BITS-1:0] bitmap,
    input  logic [SEQ_W-1:0]       start,
    output chk_result_t            result
);

    logic [EPOCH_W-1:0]     epoch;
    logic [SEQ_W-1:0]       seq;
    logic [SEQ_W-1:0]       diff;
    logic                   in_window;
    logic [OFF_W-1:0]       off;
    logic [WINDOW_BITS-1:0] marked;
    logic [CNT_W-1:0]       ones_cnt;

    assign epoch     = record_number[RECORD_W-1:SEQ_W];
    assign seq       = record_number[SEQ_W-1:0];
    assign diff      = seq - start;
    assign in_window = (seq > start) && (diff <= SEQ_W'(WINDOW_BITS));
    assign off       = OFF_W'(diff - SEQ_W'(1));

    always_comb begin
        marked      = bitmap;
        marked[off] = 1'b1;
    end

    // Find the first clear bit from the bottom: that many ones slide out
    always_comb begin
        ones_cnt = CNT_W'(WINDOW_BITS);
        for (int i = WINDOW_BITS - 1; i >= 0; i--) begin
            if (!marked[i]) begin
                ones_cnt = CNT_W'(i);
            end
        end
    end

    always_comb begin
        result.bitmap = bitmap;
        result.start  = start;
        if (epoch != current_epoch) begin
            result.status = ST_WRONG_EPOCH;
        end else if (!in_window) begin
            result.status = ST_OUTSIDE;
        end else if (bitmap[off]) begin
            result.status = ST_DUPLICATE;
        end else begin
            result.status = ST_ACCEPTED;
            result.bitmap = marked >> ones_cnt;
            result.start  = start + SEQ_W'(ones_cnt);
        end
    end

endmodule

// ===== hdl/dtls_replay_window.sv =====
// Top level of the DTLS anti-replay sliding window.
//
// Usage:
//   s_ channel: one 64-bit DTLS record number per item (epoch in bits 63:48,
//   sequence in bits 47:0). m_ channel: one result per item, carrying the
//   status code and the window start after that item. cfg channel: write
//   the current epoch; write it only while no item is in flight.
//
// Timing: an item accepted at a rising edge is held in the input register;
// the check runs and the result register loads at the first edge at which
// that register is free or draining, raising m_tvalid. One item per cycle
// is sustained while m_tready stays high; the rate is set by the single
// pass of the check logic (range compare, trailing-ones search, shift and
// start add) between the input register and the result register, which
// also updates the window.
//
// Reset (aresetn low, synchronous): clear the bitmap, start and epoch to
// zero and empty both pipeline registers.
//
// Stall: while a held result waits on m_tready the result and the window
// state do not move; the input register still takes one item if it is empty.
module dtls_replay_window
    import dtlsrw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [RECORD_W-1:0]   s_tdata,   // [63:0] record_number

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] status, [49:2] window_start, rest zero

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [EPOCH_W-1:0]    cfg_data   // current_epoch
);

    logic                   in_valid_reg;
    logic [RECORD_W-1:0]    in_data_reg;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [SEQ_W-1:0]       out_start_reg;
    logic [EPOCH_W-1:0]     epoch_reg;
    logic [WINDOW_BITS-1:0] bitmap_reg;
    logic [SEQ_W-1:0]       start_reg;

    logic                   advance;
    chk_result_t            chk;

    // Advance the held item whenever the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    dtlsrw_check u_check (
        .record_number (in_data_reg),
        .current_epoch (epoch_reg),
        .bitmap        (bitmap_reg),
        .start         (start_reg),
        .result        (chk)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // Window state: update only when a checked item moves into the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitmap_reg <= '0;
            start_reg  <= '0;
        end else if (advance) begin
            bitmap_reg <= chk.bitmap;
            start_reg  <= chk.start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            epoch_reg <= cfg_data;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= chk.status;
            out_start_reg  <= chk.start;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_start_reg, out_status_reg};

endmodule

// ===== hdl/dtlsrw_checker.sv =====
// Port-level assertions for the DTLS replay window, bound to the top level.
module dtlsrw_checker
    import dtlsrw_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [RECORD_W-1:0]   s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A waiting input item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input item changed while waiting");

    // Reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With no result pending the block always takes an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // An accepted item reaches the output once the receiver drains
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("accepted item did not reach the output");

endmodule

bind dtls_replay_window dtlsrw_checker u_dtlsrw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

// ===== bench/dtls_replay_window_test.sv =====
// Self-checking bench for the DTLS anti-replay sliding window.
module dtls_replay_window_test;
    import dtlsrw_pkg::*;

    typedef struct packed {
        logic [EPOCH_W-1:0]     epoch;
        logic [WINDOW_BITS-1:0] seen;
        logic [SEQ_W-1:0]       start;
    } window_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEQ_W-1:0]    start;
    } verdict_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [RECORD_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [EPOCH_W-1:0]    cfg_data  = '0;

    // Two copies of the window: one follows the items as they are queued (to
    // aim the stimulus), the other follows the items as the block takes them.
    window_t             queued_window   = '0;
    window_t             accepted_window = '0;
    logic [RECORD_W-1:0] pending_records[$];
    verdict_t            expected_verdicts[$];

    logic in_fire     = 1'b0;
    logic long_hold   = 1'b0;
    logic rand_started = 1'b0;

    int errors         = 0;
    int queued_count   = 0;
    int epoch_settings = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int full_shifts    = 0;
    int stall_run      = 0;
    int stall_longest  = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int rx_cycle       = 0;
    int rx_mode        = 0;

    dtls_replay_window u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run one record through a window: epoch first, then range, then the
    // duplicate bit; on acceptance set the bit and shift out trailing ones.
    function automatic verdict_t check_record(inout window_t w,
                                              input logic [RECORD_W-1:0] rec);
        verdict_t         v;
        logic [SEQ_W-1:0] sq;
        logic [SEQ_W-1:0] rel;
        logic [OFF_W-1:0] off;
        sq = rec[SEQ_W-1:0];
        if (rec[RECORD_W-1:SEQ_W] != w.epoch) begin
            v.status = ST_WRONG_EPOCH;
        end else if (!(sq > w.start && (sq - w.start) <= SEQ_W'(WINDOW_BITS))) begin
            v.status = ST_OUTSIDE;
        end else begin
            rel = sq - w.start - SEQ_W'(1);
            off = rel[OFF_W-1:0];
            if (w.seen[off]) begin
                v.status = ST_DUPLICATE;
            end else begin
                w.seen[off] = 1'b1;
                for (int i = 0; i < WINDOW_BITS; i++) begin
                    if (!w.seen[0]) break;
                    w.seen  = w.seen >> 1;
                    w.start = w.start + SEQ_W'(1);
                end
                v.status = ST_ACCEPTED;
            end
        end
        v.start = w.start;
        return v;
    endfunction

    task automatic queue_record(input logic [RECORD_W-1:0] rec);
        verdict_t ignored;
        ignored = check_record(queued_window, rec);
        pending_records.push_back(rec);
        queued_count++;
    endtask

    // Fill the offsets 1..span above the current start, shuffled or in falling
    // order (the latter sets bit 0 last, so a full span empties the bitmap).
    task automatic queue_sweep(input int span, input logic descending);
        logic [SEQ_W-1:0] base;
        int               offs[$];
        int               j;
        int               t;
        int               tmp;
        base = queued_window.start;
        for (j = span; j >= 1; j--) offs.push_back(j);
        if (!descending) begin
            for (j = span - 1; j > 0; j--) begin
                t       = $urandom_range(0, j);
                tmp     = offs[j];
                offs[j] = offs[t];
                offs[t] = tmp;
            end
        end
        foreach (offs[k]) begin
            queue_record({queued_window.epoch, base + SEQ_W'(offs[k])});
            if ($urandom_range(0, 7) == 0)
                queue_record({queued_window.epoch, base + SEQ_W'(offs[k])});
        end
    endtask

    task automatic write_epoch(input logic [EPOCH_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        accepted_window.epoch = value;
        queued_window.epoch   = value;
        epoch_settings++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued item has gone in and every result has come
    // back, then let the two pipeline stages drain.
    task automatic wait_idle();
        while (pending_records.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Sender: bursts of random length, random gaps between them; no gaps
    // while the receiver is holding off, so the block backs up.
    always @(negedge aclk) begin : record_driver
        logic                offer;
        logic [RECORD_W-1:0] next_rec;
        offer    = s_tvalid && !in_fire;
        next_rec = s_tdata;
        if (!offer) begin
            if (gap_left > 0 && !long_hold) begin
                gap_left--;
            end else if (pending_records.size() > 0) begin
                next_rec = pending_records.pop_front();
                offer    = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_tvalid <= offer;
        s_tdata  <= next_rec;
    end

    // Receiver: a stall pattern that switches at random among four modes.
    always @(negedge aclk) begin : result_sink
        logic rdy;
        rx_cycle++;
        if (rx_cycle % 40 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = rx_cycle[0];
            2:       rdy = ($urandom_range(0, 1) == 1);
            default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        if (long_hold) rdy = 1'b0;
        m_tready <= rdy;
    end

    // Long hold-off once the random part has queued a backlog.
    initial begin : receiver_hold
        wait (rand_started);
        while (pending_records.size() < 30) @(posedge aclk);
        long_hold = 1'b1;
        repeat (80) @(posedge aclk);
        long_hold = 1'b0;
    end

    // Predict on every accepted item; check every accepted result in order.
    always @(posedge aclk) begin : result_monitor
        verdict_t         want;
        verdict_t         got;
        logic [SEQ_W-1:0] prev_start;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                prev_start = accepted_window.start;
                want = check_record(accepted_window, s_tdata);
                if (want.start - prev_start == SEQ_W'(WINDOW_BITS)) full_shifts++;
                expected_verdicts.push_back(want);
            end
            if (s_tvalid && !s_tready) begin
                stall_run++;
                if (stall_run > stall_longest) stall_longest = stall_run;
            end else begin
                stall_run = 0;
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[STATUS_W-1:0];
                got.start  = m_tdata[STATUS_W +: SEQ_W];
                if (expected_verdicts.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, %s 0x%012h",
                             $time, $sformatf("got status %0d start", got.status),
                             got.start);
                end else begin
                    want = expected_verdicts.pop_front();
                    status_seen[got.status]++;
                    if (got.status != want.status) begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.start != want.start) begin
                        errors++;
                        $display("%0t: window start mismatch, expected 0x%012h, got 0x%012h",
                                 $time, want.start, got.start);
                    end
                    if (m_tdata[OUT_DATA_W-1:OUT_BITS] != '0) begin
                        errors++;
                        $display("%0t: padding mismatch, expected 0, got 0x%0h",
                                 $time, m_tdata[OUT_DATA_W-1:OUT_BITS]);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [EPOCH_W-1:0] phase_epoch[4];
        logic [SEQ_W-1:0]   rnd_seq;
        int                 target;
        int                 pick;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: window edges, duplicates, wrong epochs, field extremes.
        write_epoch(16'h0000);
        queue_record({16'h0000, 48'd0});             // equal to start: outside
        queue_record({16'h0000, 48'd1});             // accepted, start moves to 1
        queue_record({16'h0000, 48'd1});             // now at start: outside
        queue_record({16'h0000, 48'd3});             // accepted with a hole below
        queue_record({16'h0000, 48'd3});             // duplicate
        queue_record({16'h0000, 48'd65});            // top edge of the window
        queue_record({16'h0000, 48'd66});            // just above the window
        queue_record({16'h0000, 48'd2});             // fills the hole, start jumps
        queue_record({16'h0001, 48'd4});             // wrong epoch
        queue_record({16'hFFFF, 48'd4});             // wrong epoch, all ones
        queue_record({RECORD_W{1'b1}});              // all ones record
        queue_record({16'h0000, 48'hFFFF_FFFF_FFFF}); // largest sequence
        queue_record({16'h0000, 48'h8000_0000_0000});
        queue_record({16'h0000, 48'd65});            // duplicate near the top
        wait_idle();
        write_epoch(16'hFFFF);
        queue_record({16'hFFFF, 48'd4});
        queue_record({16'h0000, 48'd5});             // old epoch now wrong
        queue_record({16'hFFFF, 48'd67});
        queue_record({16'hFFFF, 48'd68});            // top edge again
        queue_record({16'hFFFF, 48'd69});
        queue_record({16'hFFFF, 48'd5});
        queue_record({16'hFFFE, 48'd6});
        queue_record({16'hFFFF, 48'd0});             // below the window
        wait_idle();

        // Random: mostly sweeps across the window, the rest noise and edges.
        phase_epoch[0] = 16'h0000;
        phase_epoch[1] = 16'($urandom);
        phase_epoch[2] = 16'hFFFF;
        phase_epoch[3] = 16'($urandom);
        for (int p = 0; p < 4; p++) begin
            write_epoch(phase_epoch[p]);
            target = queued_count + 100;
            while (queued_count < target) begin
                pick = $urandom_range(0, 9);
                if (pick <= 5) begin
                    if ($urandom_range(0, 5) == 0)
                        queue_sweep(WINDOW_BITS, $urandom_range(0, 1) == 1);
                    else
                        queue_sweep($urandom_range(1, 12), $urandom_range(0, 3) == 0);
                end else if (pick == 6) begin
                    queue_record({$urandom, $urandom});
                end else if (pick == 7) begin
                    rnd_seq = SEQ_W'({$urandom, $urandom});
                    queue_record({queued_window.epoch, rnd_seq});
                end else if (pick == 8) begin
                    case ($urandom_range(0, 2))
                        0:       rnd_seq = queued_window.start;
                        1:       rnd_seq = queued_window.start + SEQ_W'(WINDOW_BITS);
                        default: rnd_seq = queued_window.start + SEQ_W'(WINDOW_BITS + 1);
                    endcase
                    queue_record({queued_window.epoch, rnd_seq});
                end else begin
                    rnd_seq = queued_window.start + SEQ_W'($urandom_range(1, WINDOW_BITS));
                    queue_record({queued_window.epoch ^ (16'd1 << $urandom_range(0, 15)),
                                  rnd_seq});
                end
            end
            rand_started = 1'b1;
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        $display("Covered %0d records under %0d epoch settings: %0d accepted, %0d wrong epoch,",
                 queued_count, epoch_settings, status_seen[ST_ACCEPTED],
                 status_seen[ST_WRONG_EPOCH]);
        $display("%0d outside window, %0d duplicate, %0d full-window shifts,",
                 status_seen[ST_OUTSIDE], status_seen[ST_DUPLICATE], full_shifts);
        $display("input stall up to %0d cycles", stall_longest);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Give up if the results stop coming.
    initial begin : watchdog
        #(12 * 200000);
        $display("Timed out with %0d results outstanding", expected_verdicts.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dtlsrw_pkg.sv
hdl/dtlsrw_check.sv
hdl/dtls_replay_window.sv
hdl/dtlsrw_checker.sv
bench/dtls_replay_window_test.sv
